[src/alhd_pkg.sv]
// Shared types and constants for the ambient light headlight dimmer.
`timescale 1ns / 1ps

package alhd_pkg;

  // Duty and hold band constants.
  localparam logic [9:0]  DUTY_MAX   = 10'd999;
  localparam logic [9:0]  FAULT_DUTY = 10'd500;
  localparam logic [9:0]  RAMP_STEP  = 10'd10;
  localparam logic [15:0] HOLD_BAND  = 16'd20;

  // Lux conversion: lux = raw * LUX_MUL / LUX_DIV.
  localparam logic [3:0]  LUX_MUL = 4'd10;
  localparam logic [15:0] LUX_DIV = 16'd12;

  // Bit-serial divider sizing: the dividend holds up to 16 by 10 bits.
  localparam int DIV_W = 26;
  localparam int CNT_W = 5;

  // Beat layouts.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;

  // Light modes as reported on the output.
  typedef enum logic [1:0] {
    MODE_NIGHT  = 2'd0,
    MODE_CLOUDY = 2'd1,
    MODE_DAY    = 2'd2,
    MODE_FAULT  = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_NIGHT_IN_LUX   = 3'd0,
    REG_NIGHT_OUT_LUX  = 3'd1,
    REG_DAY_ENTER_LUX  = 3'd2,
    REG_DAY_EXIT_LUX   = 3'd3,
    REG_NIGHT_ENTER_MS = 3'd4,
    REG_NIGHT_EXIT_MS  = 3'd5,
    REG_DAY_ENTER_MS   = 3'd6,
    REG_DAY_EXIT_MS    = 3'd7
  } cfg_idx_t;

  // Item sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DIV      = 3'd1,
    ST_SAMP_UPD = 3'd2,
    ST_CTRL_PRE = 3'd3,
    ST_GOAL     = 3'd4,
    ST_RAMP     = 3'd5,
    ST_OUT      = 3'd6
  } state_t;

endpackage

[src/ambient_light_headlight_dimmer_core.sv]
// Top level of the ambient light headlight dimmer: filter, mode machine and duty ramp.
`timescale 1ns / 1ps

// Each input beat yields exactly one output beat. A sample beat with a
// good reading runs the lux conversion through a shared restoring divider
// that resolves one quotient bit per cycle over 26 steps. A control beat in
// cloudy mode whose lux lies strictly between the ramp thresholds uses the
// same divider for the interpolation, then sets the goal and takes a ramp
// step. A cloudy control beat at or beyond a ramp threshold takes only the
// ramp step, a control beat in night, daylight or fault mode skips it, and
// a failed read goes straight to the result stage. The result stage also
// waits for as long as the output register still holds a beat that was
// not taken. One beat is worked on at a time; the input is ready again in
// the cycle after the result is registered, while that result may still
// wait in the output register. Configuration writes are taken in any cycle
// and are meant to be issued while idle.
module ambient_light_headlight_dimmer_core
  import alhd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input channel.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: raw_count[15:0], read_failed[16], now_ms[48:17], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: op[0]
  input  logic                  s_tuser,
  // Output channel.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: duty[9:0], target_duty[19:10], light_mode[21:20],
  // filt_lux[37:22], hold_lux[53:38], fault_total[85:54], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // Input field views.
  logic [15:0] raw_count;
  logic        read_failed;
  logic [31:0] now_ms;
  assign raw_count   = s_tdata[15:0];
  assign read_failed = s_tdata[16];
  assign now_ms      = s_tdata[48:17];

  // Configuration registers.
  logic [15:0] night_in_lux, night_out_lux, day_enter_lux, day_exit_lux;
  logic [15:0] night_enter_ms, night_exit_ms, day_enter_ms, day_exit_ms;

  // Block state.
  logic [15:0] filter_value;
  logic        filter_seeded;
  logic        fault_flag;
  logic [31:0] fault_counter;
  logic [15:0] held_lux;
  logic        held_first;
  mode_t       mode_now;
  mode_t       mode_pending;
  logic        change_pending;
  logic [31:0] change_start_ms;
  logic [9:0]  duty_now;
  logic [9:0]  duty_goal;

  // Sequencer and divider.
  state_t             state, state_next;
  logic               is_ctrl;
  logic [DIV_W-1:0]   dvd;
  logic [15:0]        rem;
  logic [15:0]        dvs;
  logic [CNT_W-1:0]   cnt;

  logic               in_beat;
  logic               out_free;

  assign in_beat   = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      night_in_lux    <= 16'd500;
      night_out_lux   <= 16'd600;
      day_enter_lux   <= 16'd2000;
      day_exit_lux    <= 16'd1800;
      night_enter_ms  <= 16'd500;
      night_exit_ms   <= 16'd300;
      day_enter_ms    <= 16'd2000;
      day_exit_ms     <= 16'd300;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_NIGHT_IN_LUX:   night_in_lux    <= cfg_data;
        REG_NIGHT_OUT_LUX:  night_out_lux   <= cfg_data;
        REG_DAY_ENTER_LUX:  day_enter_lux   <= cfg_data;
        REG_DAY_EXIT_LUX:   day_exit_lux    <= cfg_data;
        REG_NIGHT_ENTER_MS: night_enter_ms  <= cfg_data;
        REG_NIGHT_EXIT_MS:  night_exit_ms   <= cfg_data;
        REG_DAY_ENTER_MS:   day_enter_ms    <= cfg_data;
        REG_DAY_EXIT_MS:    day_exit_ms     <= cfg_data;
      endcase
    end
  end

  // Hold band and mode machine for a control beat, evaluated at acceptance.
  logic [15:0] lux_diff;
  logic [15:0] held_lux_next;
  mode_t       mode_now_next;
  mode_t       mode_pending_next;
  logic        change_pending_next;
  logic [31:0] change_start_ms_next;
  mode_t       want;
  logic [15:0] qual;
  logic [31:0] elapsed;

  always_comb begin
    lux_diff = (filter_value > held_lux) ? (filter_value - held_lux)
                                         : (held_lux - filter_value);
    held_lux_next = (held_first || lux_diff >= HOLD_BAND) ? filter_value : held_lux;

    mode_now_next        = mode_now;
    mode_pending_next    = mode_pending;
    change_pending_next  = change_pending;
    change_start_ms_next = change_start_ms;
    want                 = mode_now;
    qual                 = 16'd0;
    elapsed              = 32'd0;

    if (fault_flag) begin
      mode_now_next = MODE_FAULT;
    end else if (mode_now == MODE_FAULT) begin
      // Recovery from a fault goes to cloudy and drops any pending move.
      mode_now_next       = MODE_CLOUDY;
      change_pending_next = 1'b0;
    end else begin
      unique case (mode_now)
        MODE_NIGHT: begin
          if (held_lux_next > night_out_lux) begin
            want = MODE_CLOUDY;
            qual = night_exit_ms;
          end
        end
        MODE_CLOUDY: begin
          if (held_lux_next < night_in_lux) begin
            want = MODE_NIGHT;
            qual = night_enter_ms;
          end else if (held_lux_next > day_enter_lux) begin
            want = MODE_DAY;
            qual = day_enter_ms;
          end
        end
        MODE_DAY: begin
          if (held_lux_next < day_exit_lux) begin
            want = MODE_CLOUDY;
            qual = day_exit_ms;
          end
        end
        default: begin
          want = mode_now;
        end
      endcase

      if (want != mode_now) begin
        if (!change_pending || mode_pending != want) begin
          mode_pending_next    = want;
          change_start_ms_next = now_ms;
        end
        change_pending_next = 1'b1;
        elapsed = now_ms - change_start_ms_next;
        if (elapsed >= {16'd0, qual}) begin
          mode_now_next       = mode_pending_next;
          change_pending_next = 1'b0;
        end
      end else begin
        change_pending_next = 1'b0;
      end
    end
  end

  // Divider step: one quotient bit per cycle.
  logic [16:0] trial;
  logic        qbit;
  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  // Filter update from the converted lux held in the quotient.
  logic [15:0] lux_new;
  logic [17:0] filt_sum;
  assign lux_new  = dvd[15:0];
  assign filt_sum = {1'b0, filter_value, 1'b0} + {2'b00, filter_value} + {2'b00, lux_new};

  // Cloudy ramp step toward the goal.
  logic [9:0] duty_ramp;
  always_comb begin
    duty_ramp = duty_now;
    if (duty_now < duty_goal) begin
      duty_ramp = ((duty_goal - duty_now) <= RAMP_STEP) ? duty_goal : (duty_now + RAMP_STEP);
    end else if (duty_now > duty_goal) begin
      duty_ramp = ((duty_now - duty_goal) <= RAMP_STEP) ? duty_goal : (duty_now - RAMP_STEP);
    end
  end

  // Interpolation product for cloudy mode.
  logic [DIV_W-1:0] interp_num;
  assign interp_num = DIV_W'(day_enter_lux - held_lux) * DIV_W'(DUTY_MAX);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_tuser) begin
            state_next = ST_CTRL_PRE;
          end else if (read_failed) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_W - 1)) begin
          state_next = is_ctrl ? ST_GOAL : ST_SAMP_UPD;
        end
      end
      ST_SAMP_UPD: state_next = ST_OUT;
      ST_CTRL_PRE: begin
        if (mode_now != MODE_CLOUDY) begin
          state_next = ST_OUT;
        end else if (held_lux <= night_out_lux || held_lux >= day_enter_lux) begin
          state_next = ST_RAMP;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_GOAL: state_next = ST_RAMP;
      ST_RAMP: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_value    <= 16'd0;
      filter_seeded   <= 1'b0;
      fault_flag      <= 1'b0;
      fault_counter   <= 32'd0;
      held_lux        <= 16'd0;
      held_first      <= 1'b1;
      mode_now        <= MODE_CLOUDY;
      mode_pending    <= MODE_CLOUDY;
      change_pending  <= 1'b0;
      change_start_ms <= 32'd0;
      duty_now        <= 10'd0;
      duty_goal       <= 10'd0;
      is_ctrl         <= 1'b0;
      cnt             <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      // A taken beat leaves the output register unless a new one lands now.
      if (m_tvalid && m_tready && !(state == ST_OUT && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            cnt     <= '0;
            is_ctrl <= s_tuser;
            if (s_tuser) begin
              held_lux        <= held_lux_next;
              held_first      <= 1'b0;
              mode_now        <= mode_now_next;
              mode_pending    <= mode_pending_next;
              change_pending  <= change_pending_next;
              change_start_ms <= change_start_ms_next;
            end else if (read_failed) begin
              fault_flag    <= 1'b1;
              fault_counter <= fault_counter + 32'd1;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + CNT_W'(1);
        end
        ST_SAMP_UPD: begin
          fault_flag    <= 1'b0;
          filter_seeded <= 1'b1;
          filter_value  <= filter_seeded ? filt_sum[17:2] : lux_new;
        end
        ST_CTRL_PRE: begin
          cnt <= '0;
          unique case (mode_now)
            MODE_NIGHT: begin
              duty_goal <= DUTY_MAX;
              duty_now  <= DUTY_MAX;
            end
            MODE_DAY: begin
              duty_goal <= 10'd0;
              duty_now  <= 10'd0;
            end
            MODE_FAULT: begin
              duty_goal <= FAULT_DUTY;
              duty_now  <= FAULT_DUTY;
            end
            MODE_CLOUDY: begin
              if (held_lux <= night_out_lux) begin
                duty_goal <= DUTY_MAX;
              end else if (held_lux >= day_enter_lux) begin
                duty_goal <= 10'd0;
              end
            end
          endcase
        end
        ST_GOAL: begin
          duty_goal <= dvd[9:0];
        end
        ST_RAMP: begin
          duty_now <= duty_ramp;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  // Divider datapath and output register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_beat && !s_tuser) begin
      dvd <= DIV_W'(raw_count) * DIV_W'(LUX_MUL);
      dvs <= LUX_DIV;
      rem <= 16'd0;
    end else if (state == ST_CTRL_PRE) begin
      dvd <= interp_num;
      dvs <= day_enter_lux - night_out_lux;
      rem <= 16'd0;
    end else if (state == ST_DIV) begin
      rem <= qbit ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      dvd <= {dvd[DIV_W-2:0], qbit};
    end

    if (state == ST_OUT && out_free) begin
      m_tdata <= {2'b00, fault_counter, held_lux, filter_value, mode_now,
                  duty_goal, duty_now};
    end
  end

endmodule

[test/tb.sv]
// Self-checking testbench for the ambient light headlight dimmer core.
`timescale 1ns / 1ps

module tb;
  import alhd_pkg::*;

  localparam int STALL_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 250;
  localparam int PHASE_COUNT     = 6;
  localparam int MAX_REPORTS     = 100;
  localparam int LUX_TOP         = 54612;

  // Item kinds carried on s_tuser.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_CONTROL = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] raw;
    logic        failed;
    logic [31:0] now;
  } light_item_t;

  typedef struct packed {
    logic [9:0]  duty;
    logic [9:0]  goal;
    mode_t       mode;
    logic [15:0] filt;
    logic [15:0] held;
    logic [31:0] faults;
  } dimmer_out_t;

  // DUT connections; the driven inputs are at known values from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  ambient_light_headlight_dimmer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and expectation stores.
  light_item_t pending_items[$];
  dimmer_out_t expected_outs[$];
  bit          item_taken = 1'b0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic [31:0] clock_ms = '0;
  int          step_ms_max = 700;

  // Predictor state: register shadow, filter, fault tracking, mode machine, ramp.
  logic [15:0] cfg_shadow [8] = '{16'd500, 16'd600, 16'd2000, 16'd1800,
                                  16'd500, 16'd300, 16'd2000, 16'd300};
  logic [15:0] avg_lux = '0;
  bit          avg_seeded = 1'b0;
  bit          read_fault = 1'b0;
  logic [31:0] fault_count = '0;
  logic [15:0] held_lux = '0;
  bit          held_fresh = 1'b1;
  mode_t       cur_mode = MODE_CLOUDY;
  mode_t       next_mode = MODE_CLOUDY;
  bit          move_armed = 1'b0;
  logic [31:0] move_start_ms = '0;
  logic [9:0]  duty_cur = '0;
  logic [9:0]  duty_goal = '0;

  // Duty goal in cloudy mode: linear between the night exit and day entry levels.
  function automatic logic [9:0] cloudy_duty(input logic [15:0] lux);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] scaled;
    lo = cfg_shadow[REG_NIGHT_OUT_LUX];
    hi = cfg_shadow[REG_DAY_ENTER_LUX];
    if (lux <= lo) return DUTY_MAX;
    if (lux >= hi) return 10'd0;
    if (hi <= lo) return 10'd0;
    scaled = 32'(hi - lux) * 32'(DUTY_MAX);
    return 10'(scaled / 32'(hi - lo));
  endfunction

  // One control step of the night/cloudy/daylight machine with persistence.
  task automatic advance_mode(input logic [15:0] lux, input logic [31:0] now);
    mode_t       want;
    logic [15:0] qual;
    want = cur_mode;
    qual = '0;
    if (cur_mode == MODE_FAULT) begin
      // Leaving fault drops any pending move and takes no other move.
      cur_mode = MODE_CLOUDY;
      move_armed = 1'b0;
    end else begin
      case (cur_mode)
        MODE_NIGHT: begin
          if (lux > cfg_shadow[REG_NIGHT_OUT_LUX]) begin
            want = MODE_CLOUDY;
            qual = cfg_shadow[REG_NIGHT_EXIT_MS];
          end
        end
        MODE_CLOUDY: begin
          if (lux < cfg_shadow[REG_NIGHT_IN_LUX]) begin
            want = MODE_NIGHT;
            qual = cfg_shadow[REG_NIGHT_ENTER_MS];
          end else if (lux > cfg_shadow[REG_DAY_ENTER_LUX]) begin
            want = MODE_DAY;
            qual = cfg_shadow[REG_DAY_ENTER_MS];
          end
        end
        default: begin
          if (lux < cfg_shadow[REG_DAY_EXIT_LUX]) begin
            want = MODE_CLOUDY;
            qual = cfg_shadow[REG_DAY_EXIT_MS];
          end
        end
      endcase
      if (want != cur_mode) begin
        if (!move_armed || next_mode != want) begin
          next_mode = want;
          move_start_ms = now;
          move_armed = 1'b1;
        end
        // Elapsed time wraps modulo 2^32.
        if (32'(now - move_start_ms) >= 32'(qual)) begin
          cur_mode = next_mode;
          move_armed = 1'b0;
        end
      end else begin
        move_armed = 1'b0;
      end
    end
  endtask

  // Applies one accepted item to the predictor and returns the expected beat.
  task automatic predict_dimmer(input light_item_t it, output dimmer_out_t res);
    logic [31:0] lux32;
    logic [15:0] diff;
    if (it.op == OP_SAMPLE) begin
      if (it.failed) begin
        read_fault = 1'b1;
        fault_count = fault_count + 32'd1;
      end else begin
        lux32 = 32'(it.raw) * 32'(LUX_MUL) / 32'(LUX_DIV);
        read_fault = 1'b0;
        if (!avg_seeded) begin
          avg_lux = lux32[15:0];
          avg_seeded = 1'b1;
        end else begin
          avg_lux = 16'((32'(avg_lux) * 32'd3 + lux32) / 32'd4);
        end
      end
    end else begin
      diff = (avg_lux > held_lux) ? avg_lux - held_lux : held_lux - avg_lux;
      if (held_fresh || diff >= HOLD_BAND) begin
        held_lux = avg_lux;
        held_fresh = 1'b0;
      end
      if (read_fault) cur_mode = MODE_FAULT;
      else advance_mode(held_lux, it.now);
      case (cur_mode)
        MODE_NIGHT: begin
          duty_goal = DUTY_MAX;
          duty_cur = DUTY_MAX;
        end
        MODE_CLOUDY: begin
          duty_goal = cloudy_duty(held_lux);
          if (duty_cur < duty_goal) begin
            duty_cur = (duty_goal - duty_cur <= RAMP_STEP) ? duty_goal : duty_cur + RAMP_STEP;
          end else if (duty_cur > duty_goal) begin
            duty_cur = (duty_cur - duty_goal <= RAMP_STEP) ? duty_goal : duty_cur - RAMP_STEP;
          end
        end
        MODE_DAY: begin
          duty_goal = 10'd0;
          duty_cur = 10'd0;
        end
        default: begin
          duty_goal = FAULT_DUTY;
          duty_cur = FAULT_DUTY;
        end
      endcase
    end
    res.duty = duty_cur;
    res.goal = duty_goal;
    res.mode = cur_mode;
    res.filt = avg_lux;
    res.held = held_lux;
    res.faults = fault_count;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Input side: predict every beat taken by the block.
  always @(posedge clk) begin : take_side
    dimmer_out_t res;
    if (!rst && s_tvalid && s_tready) begin
      predict_dimmer(pending_items.pop_front(), res);
      expected_outs.push_back(res);
      item_taken = 1'b1;
    end
  end

  // Input driver: holds an offered beat until taken, otherwise offers at random.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !item_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_items[0].op;
        s_tdata <= IN_DATA_W'({pending_items[0].now, pending_items[0].failed,
                               pending_items[0].raw});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // Output ready: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor: compare every result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    dimmer_out_t got;
    dimmer_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.duty = m_tdata[9:0];
      got.goal = m_tdata[19:10];
      got.mode = mode_t'(m_tdata[21:20]);
      got.filt = m_tdata[37:22];
      got.held = m_tdata[53:38];
      got.faults = m_tdata[85:54];
      if (expected_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing predicted, expected none, actual %h",
                   $time, m_tdata);
      end else begin
        want = expected_outs.pop_front();
        check_field("duty", 32'(want.duty), 32'(got.duty));
        check_field("target_duty", 32'(want.goal), 32'(got.goal));
        check_field("light_mode", 32'(want.mode), 32'(got.mode));
        check_field("filt_lux", 32'(want.filt), 32'(got.filt));
        check_field("hold_lux", 32'(want.held), 32'(got.held));
        check_field("fault_total", want.faults, got.faults);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  task automatic push_item(input logic op, input logic [15:0] raw, input logic failed,
                           input logic [31:0] now);
    light_item_t it;
    it.op = op;
    it.raw = raw;
    it.failed = failed;
    it.now = now;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_outs.size() != 0 || s_tvalid)
      @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_shadow[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes all eight registers for one phase and sizes the tick steps to match.
  task automatic load_setting(input int sel);
    logic [15:0] vals [8];
    int          longest;
    case (sel)
      0: vals = '{16'd500, 16'd600, 16'd2000, 16'd1800, 16'd500, 16'd300, 16'd2000, 16'd300};
      1: vals = '{default: 16'd0};
      2: vals = '{default: 16'hFFFF};
      // Ramp thresholds crossed over, so the cloudy span is not positive.
      3: vals = '{16'd2500, 16'd3000, 16'd1000, 16'd1500, 16'd40, 16'd0, 16'd100, 16'd900};
      4: begin
        vals[REG_NIGHT_IN_LUX] = 16'($urandom_range(3000));
        vals[REG_NIGHT_OUT_LUX] = vals[REG_NIGHT_IN_LUX] + 16'($urandom_range(500));
        vals[REG_DAY_ENTER_LUX] = vals[REG_NIGHT_OUT_LUX] + 16'($urandom_range(1, 6000));
        vals[REG_DAY_EXIT_LUX] = vals[REG_DAY_ENTER_LUX] - 16'($urandom_range(400));
        vals[REG_NIGHT_ENTER_MS] = 16'($urandom_range(3000));
        vals[REG_NIGHT_EXIT_MS] = 16'($urandom_range(3000));
        vals[REG_DAY_ENTER_MS] = 16'($urandom_range(3000));
        vals[REG_DAY_EXIT_MS] = 16'($urandom_range(3000));
      end
      default: begin
        foreach (vals[i]) vals[i] = 16'($urandom);
      end
    endcase
    longest = 0;
    foreach (vals[i]) begin
      cfg_write(cfg_idx_t'(i), vals[i]);
      if (i >= int'(REG_NIGHT_ENTER_MS) && int'(vals[i]) > longest) longest = int'(vals[i]);
    end
    step_ms_max = longest / 3 + 20;
  endtask

  function automatic int clamp_lux(input int v);
    if (v < 0) return 0;
    if (v > LUX_TOP) return LUX_TOP;
    return v;
  endfunction

  // Light level for a scene: near a threshold, anywhere, or at an end of the range.
  function automatic int pick_level();
    int base;
    case ($urandom_range(5))
      0: base = int'(cfg_shadow[REG_NIGHT_IN_LUX]);
      1: base = int'(cfg_shadow[REG_NIGHT_OUT_LUX]);
      2: base = int'(cfg_shadow[REG_DAY_ENTER_LUX]);
      3: base = int'(cfg_shadow[REG_DAY_EXIT_LUX]);
      4: base = int'($urandom_range(LUX_TOP));
      default: base = ($urandom_range(1) != 0) ? 0 : LUX_TOP;
    endcase
    return clamp_lux(base + int'($urandom_range(60)) - 30);
  endfunction

  // Random traffic: mostly scenes of sample/control pairs at a steady light
  // level with a forward-running tick, plus some fully random beats.
  task automatic gen_traffic(input int count);
    int made;
    int base;
    int lux;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) == 0) begin
        push_item(1'($urandom), 16'($urandom), 1'($urandom), $urandom);
        made++;
      end else begin
        base = pick_level();
        repeat ($urandom_range(2, 10)) begin
          lux = clamp_lux(base + int'($urandom_range(16)) - 8);
          push_item(OP_SAMPLE, 16'(lux * 6 / 5), ($urandom_range(24) == 0), $urandom);
          clock_ms = clock_ms + $urandom_range(step_ms_max);
          push_item(OP_CONTROL, 16'($urandom), 1'($urandom), clock_ms);
          made += 2;
        end
      end
    end
  endtask

  // Main sequence: reset, directed beats, then phases of random traffic.
  initial begin : stimulus
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Control before any sample sees a zero filter; unused fields set high.
    push_item(OP_CONTROL, 16'hFFFF, 1'b1, 32'd0);
    // Seed the filter at the top of the raw range.
    push_item(OP_SAMPLE, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'd100);
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'd2100);
    push_item(OP_SAMPLE, 16'h0000, 1'b0, 32'd0);
    // Failed reads enter fault mode and count up.
    push_item(OP_SAMPLE, 16'h0000, 1'b1, 32'd0);
    push_item(OP_CONTROL, 16'hFFFF, 1'b1, 32'd2200);
    push_item(OP_SAMPLE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'd2300);
    // A good read clears the fault; the next control recovers to cloudy.
    push_item(OP_SAMPLE, 16'h0000, 1'b0, 32'd0);
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'd2400);
    // Pending move that qualifies across the tick wrap.
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'hFFFF_FF00);
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'h0000_0700);
    // Controls with no new sample stay inside the hold band.
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'h0000_0800);
    push_item(OP_SAMPLE, 16'd720, 1'b0, 32'd0);
    push_item(OP_CONTROL, 16'h0000, 1'b0, 32'h0000_0900);
    wait_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 23;
        recv_idle_pct = 58;
      end else if (phase < 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_setting(phase);
      clock_ms = $urandom;
      // Long output hold-off while beats keep coming, to back the block up.
      if (phase == 0) hold_req++;
      gen_traffic(PHASE_ITEMS / 2);
      // Sender pauses mid-phase until every result is back.
      if (phase == 1) wait_drained();
      gen_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_outs.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
